// File: rtl/ctg_pkg.sv
// Package with the types, constants and helper functions of the circle trajectory generator.
package ctg_pkg;

   localparam int CORDIC_STEPS_DEFAULT = 24;
   localparam logic [30:0] TURN_SCALE = 31'd1608495439;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [2:0] REG_RADIUS   = 3'd0;
   localparam logic [2:0] REG_SPEED    = 3'd1;
   localparam logic [2:0] REG_HEIGHT   = 3'd2;
   localparam logic [2:0] REG_CENTRE_X = 3'd3;
   localparam logic [2:0] REG_CENTRE_Y = 3'd4;
   localparam logic [2:0] REG_YAW_MODE = 3'd5;
   localparam logic [2:0] REG_TICK     = 3'd6;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TIME, ST_MULD, ST_MODA, ST_MODA_RUN, ST_MODB, ST_MODB_RUN,
      ST_MM_DBL, ST_MM_ADD, ST_FRAC, ST_FRAC_RUN, ST_ANG, ST_CORD, ST_QUAD,
      ST_M_PC, ST_M_PS, ST_M_PX, ST_M_PY, ST_M_AX, ST_DIVX, ST_DIVX_RUN,
      ST_M_AY, ST_DIVY, ST_DIVY_RUN, ST_DONE
   } state_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [39:0] v);
      logic [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -40'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Signed result of a quotient magnitude, clamped to 32 bits.
   function automatic logic [31:0] sat_quot(input logic neg, input logic [63:0] q);
      logic [31:0] r;
      if (!neg) begin
         r = (q > 64'd2147483647) ? 32'h7FFF_FFFF : q[31:0];
      end else begin
         r = (q > 64'd2147483648) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
      end
      return r;
   endfunction

endpackage

// File: rtl/circle_trajectory_generator.sv
// Circle trajectory generator: one timer tick in, one position, velocity, acceleration and
// yaw setpoint out. Each request advances the elapsed time by one tick period and yields
// one response. A single shift-subtract divider does the modulo reductions, the angle
// fraction and both acceleration divisions (64 steps each, 32 for the fraction), a
// shift-add loop does the modular multiply, one CORDIC stage runs CORDIC_STEPS times,
// and one 34 by 34 bit multiplier serves all products. A new request is accepted while
// the previous response still waits to be taken.
module circle_trajectory_generator #(
   parameter int CORDIC_STEPS = ctg_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_current_yaw,
   input  logic        req_yaw_valid,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pos_x,
   output logic [31:0] rsp_pos_y,
   output logic [31:0] rsp_pos_z,
   output logic [31:0] rsp_vel_x,
   output logic [31:0] rsp_vel_y,
   output logic [31:0] rsp_acc_x,
   output logic [31:0] rsp_acc_y,
   output logic [31:0] rsp_yaw_out,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   ctg_pkg::state_type state_ff, state_in;

   logic [30:0]        radius_ff;
   logic signed [31:0] speed_ff;
   logic [31:0]        height_ff, centre_x_ff, centre_y_ff;
   logic               yaw_mode_ff;
   logic [19:0]        tick_ff;
   logic [63:0]        elapsed_ff;

   logic [31:0]        yaw_in_ff;
   logic               yaw_ok_ff;
   logic [61:0]        d_ff, a_ff, b_ff, mr_ff, den_ff;
   logic [61:0]        rem_ff;
   logic [63:0]        num_ff, quo_ff;
   logic [5:0]         cnt_ff;
   logic [31:0]        ang_ff;
   logic [1:0]         quad_ff;
   logic signed [33:0] x_ff, y_ff, c_ff, s_ff;
   logic signed [31:0] z_ff;
   logic signed [67:0] prod_ff;
   logic signed [33:0] pc_ff, ps_ff, px_ff, py_ff;
   logic               neg_ff;
   logic [31:0]        acc_x_ff;

   logic               rsp_valid_ff;
   logic [31:0]        pos_x_ff, pos_y_ff, pos_z_ff, vel_x_ff, vel_y_ff;
   logic [31:0]        acc_xo_ff, acc_y_ff, yaw_out_ff;

   logic [30:0]        r_eff;
   logic [31:0]        mag;
   logic               csr_wr;
   logic               req_acc, out_free, last_step;
   logic [62:0]        div_sh, mm_dbl, mm_sum;
   logic               div_ge;
   logic [61:0]        div_rem;
   logic [61:0]        mm_dbl_red, mm_sum_red;
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_in, prod_rnd;
   logic signed [33:0] rnd_val;
   logic signed [33:0] xs, ys;
   logic [31:0]        ang_q, res;
   logic [1:0]         q2;
   logic [63:0]        prod_mag;
   logic [31:0]        frac_ang;
   logic [31:0]        yaw_sel;

   assign r_eff  = (radius_ff == 31'd0) ? 31'd1 : radius_ff;
   assign mag    = speed_ff[31] ? (~speed_ff + 32'd1) : speed_ff;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[4:2])
         ctg_pkg::REG_RADIUS:   csr_prdata = {1'b0, radius_ff};
         ctg_pkg::REG_SPEED:    csr_prdata = speed_ff;
         ctg_pkg::REG_HEIGHT:   csr_prdata = height_ff;
         ctg_pkg::REG_CENTRE_X: csr_prdata = centre_x_ff;
         ctg_pkg::REG_CENTRE_Y: csr_prdata = centre_y_ff;
         ctg_pkg::REG_YAW_MODE: csr_prdata = {31'd0, yaw_mode_ff};
         ctg_pkg::REG_TICK:     csr_prdata = {12'd0, tick_ff};
         default:               csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= 31'd131072;
         speed_ff    <= 32'sd65536;
         height_ff   <= 32'd65536;
         centre_x_ff <= 32'd0;
         centre_y_ff <= 32'd0;
         yaw_mode_ff <= 1'b0;
         tick_ff     <= 20'd10000;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            ctg_pkg::REG_RADIUS:   radius_ff   <= csr_pwdata[30:0];
            ctg_pkg::REG_SPEED:    speed_ff    <= csr_pwdata;
            ctg_pkg::REG_HEIGHT:   height_ff   <= csr_pwdata;
            ctg_pkg::REG_CENTRE_X: centre_x_ff <= csr_pwdata;
            ctg_pkg::REG_CENTRE_Y: centre_y_ff <= csr_pwdata;
            ctg_pkg::REG_YAW_MODE: yaw_mode_ff <= csr_pwdata[0];
            ctg_pkg::REG_TICK:     tick_ff     <= csr_pwdata[19:0];
            default: begin
            end
         endcase
      end
   end

   // Shared shift-subtract divider step.
   assign div_sh  = {rem_ff, num_ff[63]};
   assign div_ge  = (div_sh >= {1'b0, den_ff});
   assign div_rem = div_ge ? 62'(div_sh - {1'b0, den_ff}) : div_sh[61:0];

   // Modular multiply steps.
   assign mm_dbl     = {mr_ff, 1'b0};
   assign mm_dbl_red = (mm_dbl >= {1'b0, d_ff}) ? 62'(mm_dbl - {1'b0, d_ff}) : mm_dbl[61:0];
   assign mm_sum     = {1'b0, mr_ff} + {1'b0, a_ff};
   assign mm_sum_red = (mm_sum >= {1'b0, d_ff}) ? 62'(mm_sum - {1'b0, d_ff}) : mm_sum[61:0];

   // Shared multiplier operand selection.
   always_comb begin
      unique case (state_ff)
         ctg_pkg::ST_MULD: begin
            mul_a = {3'b000, r_eff};
            mul_b = {3'b000, ctg_pkg::TURN_SCALE};
         end
         ctg_pkg::ST_M_PC: begin
            mul_a = 34'(speed_ff);
            mul_b = c_ff;
         end
         ctg_pkg::ST_M_PS: begin
            mul_a = 34'(speed_ff);
            mul_b = s_ff;
         end
         ctg_pkg::ST_M_PX: begin
            mul_a = {3'b000, r_eff};
            mul_b = c_ff;
         end
         ctg_pkg::ST_M_PY: begin
            mul_a = {3'b000, r_eff};
            mul_b = s_ff;
         end
         ctg_pkg::ST_M_AX: begin
            mul_a = pc_ff;
            mul_b = 34'(speed_ff);
         end
         ctg_pkg::ST_M_AY: begin
            mul_a = ps_ff;
            mul_b = 34'(speed_ff);
         end
         default: begin
            mul_a = 34'sd0;
            mul_b = 34'sd0;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_rnd = prod_ff + 68'sd536870912;
   assign rnd_val  = prod_rnd[63:30];
   assign prod_mag = prod_ff[67] ? 64'(-prod_ff) : prod_ff[63:0];

   assign xs = x_ff >>> cnt_ff[4:0];
   assign ys = y_ff >>> cnt_ff[4:0];

   assign frac_ang = speed_ff[31] ? (32'd0 - quo_ff[31:0]) : quo_ff[31:0];
   assign ang_q    = ang_ff + 32'h2000_0000;
   assign q2       = ang_q[31:30];
   assign res      = ang_ff - {q2, 30'd0};

   assign yaw_sel = yaw_mode_ff ? (ang_ff + 32'h4000_0000) :
                    (yaw_ok_ff ? yaw_in_ff : 32'd0);

   assign last_step = (cnt_ff == 6'd0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_acc   = req_valid && !req_stall;

   // Control outputs.
   always_comb begin
      req_stall = (state_ff != ctg_pkg::ST_IDLE);
      rsp_valid = rsp_valid_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ctg_pkg::ST_IDLE:     if (req_valid) state_in = ctg_pkg::ST_TIME;
         ctg_pkg::ST_TIME:     state_in = ctg_pkg::ST_MULD;
         ctg_pkg::ST_MULD:     state_in = ctg_pkg::ST_MODA;
         ctg_pkg::ST_MODA:     state_in = ctg_pkg::ST_MODA_RUN;
         ctg_pkg::ST_MODA_RUN: if (last_step) state_in = ctg_pkg::ST_MODB;
         ctg_pkg::ST_MODB:     state_in = ctg_pkg::ST_MODB_RUN;
         ctg_pkg::ST_MODB_RUN: if (last_step) state_in = ctg_pkg::ST_MM_DBL;
         ctg_pkg::ST_MM_DBL:   state_in = ctg_pkg::ST_MM_ADD;
         ctg_pkg::ST_MM_ADD:   state_in = last_step ? ctg_pkg::ST_FRAC : ctg_pkg::ST_MM_DBL;
         ctg_pkg::ST_FRAC:     state_in = ctg_pkg::ST_FRAC_RUN;
         ctg_pkg::ST_FRAC_RUN: if (last_step) state_in = ctg_pkg::ST_ANG;
         ctg_pkg::ST_ANG:      state_in = ctg_pkg::ST_CORD;
         ctg_pkg::ST_CORD: begin
            if (cnt_ff == 6'(CORDIC_STEPS - 1)) state_in = ctg_pkg::ST_QUAD;
         end
         ctg_pkg::ST_QUAD:     state_in = ctg_pkg::ST_M_PC;
         ctg_pkg::ST_M_PC:     state_in = ctg_pkg::ST_M_PS;
         ctg_pkg::ST_M_PS:     state_in = ctg_pkg::ST_M_PX;
         ctg_pkg::ST_M_PX:     state_in = ctg_pkg::ST_M_PY;
         ctg_pkg::ST_M_PY:     state_in = ctg_pkg::ST_M_AX;
         ctg_pkg::ST_M_AX:     state_in = ctg_pkg::ST_DIVX;
         ctg_pkg::ST_DIVX:     state_in = ctg_pkg::ST_DIVX_RUN;
         ctg_pkg::ST_DIVX_RUN: if (last_step) state_in = ctg_pkg::ST_M_AY;
         ctg_pkg::ST_M_AY:     state_in = ctg_pkg::ST_DIVY;
         ctg_pkg::ST_DIVY:     state_in = ctg_pkg::ST_DIVY_RUN;
         ctg_pkg::ST_DIVY_RUN: if (last_step) state_in = ctg_pkg::ST_DONE;
         ctg_pkg::ST_DONE:     if (out_free) state_in = ctg_pkg::ST_IDLE;
         default:              state_in = ctg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctg_pkg::ST_IDLE;
         elapsed_ff   <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ctg_pkg::ST_TIME) begin
            elapsed_ff <= elapsed_ff + {44'd0, tick_ff};
         end
         if (state_ff == ctg_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (req_acc) begin
         yaw_in_ff <= req_current_yaw;
         yaw_ok_ff <= req_yaw_valid;
      end
      unique case (state_ff)
         ctg_pkg::ST_MODA: begin
            d_ff   <= prod_ff[61:0];
            den_ff <= prod_ff[61:0];
            num_ff <= {24'd0, mag, 8'd0};
            rem_ff <= 62'd0;
            quo_ff <= 64'd0;
            cnt_ff <= 6'd63;
         end
         ctg_pkg::ST_MODB: begin
            a_ff   <= rem_ff;
            num_ff <= elapsed_ff;
            rem_ff <= 62'd0;
            cnt_ff <= 6'd63;
         end
         ctg_pkg::ST_MODA_RUN, ctg_pkg::ST_MODB_RUN, ctg_pkg::ST_FRAC_RUN,
         ctg_pkg::ST_DIVX_RUN, ctg_pkg::ST_DIVY_RUN: begin
            rem_ff <= div_rem;
            num_ff <= {num_ff[62:0], 1'b0};
            quo_ff <= {quo_ff[62:0], div_ge};
            if (state_ff == ctg_pkg::ST_MODB_RUN && last_step) begin
               mr_ff  <= 62'd0;
               cnt_ff <= 6'd61;
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
         ctg_pkg::ST_MM_DBL: begin
            if (mr_ff == 62'd0 && cnt_ff == 6'd61) begin
               b_ff <= rem_ff;
            end
            mr_ff <= mm_dbl_red;
         end
         ctg_pkg::ST_MM_ADD: begin
            if (b_ff[cnt_ff]) begin
               mr_ff <= mm_sum_red;
            end
            cnt_ff <= cnt_ff - 6'd1;
         end
         ctg_pkg::ST_FRAC: begin
            rem_ff <= mr_ff;
            den_ff <= d_ff;
            num_ff <= 64'd0;
            quo_ff <= 64'd0;
            cnt_ff <= 6'd31;
         end
         ctg_pkg::ST_ANG: begin
            ang_ff <= frac_ang;
            cnt_ff <= 6'd0;
         end
         ctg_pkg::ST_CORD: begin
            if (cnt_ff == 6'd0) begin
               quad_ff <= q2;
               if (res[31]) begin
                  x_ff <= ctg_pkg::CORDIC_GAIN;
                  y_ff <= 34'sd0 - ctg_pkg::CORDIC_GAIN;
                  z_ff <= $signed(res) + $signed(ctg_pkg::atan_turn(5'd0));
               end else begin
                  x_ff <= ctg_pkg::CORDIC_GAIN;
                  y_ff <= ctg_pkg::CORDIC_GAIN;
                  z_ff <= $signed(res) - $signed(ctg_pkg::atan_turn(5'd0));
               end
            end else if (!z_ff[31]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - $signed(ctg_pkg::atan_turn(cnt_ff[4:0]));
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + $signed(ctg_pkg::atan_turn(cnt_ff[4:0]));
            end
            cnt_ff <= cnt_ff + 6'd1;
         end
         ctg_pkg::ST_QUAD: begin
            unique case (quad_ff)
               2'd0: begin
                  c_ff <= x_ff;
                  s_ff <= y_ff;
               end
               2'd1: begin
                  c_ff <= -y_ff;
                  s_ff <= x_ff;
               end
               2'd2: begin
                  c_ff <= -x_ff;
                  s_ff <= -y_ff;
               end
               default: begin
                  c_ff <= y_ff;
                  s_ff <= -x_ff;
               end
            endcase
         end
         ctg_pkg::ST_M_PS: pc_ff <= rnd_val;
         ctg_pkg::ST_M_PX: ps_ff <= rnd_val;
         ctg_pkg::ST_M_PY: px_ff <= rnd_val;
         ctg_pkg::ST_M_AX: py_ff <= rnd_val;
         ctg_pkg::ST_DIVX, ctg_pkg::ST_DIVY: begin
            num_ff <= prod_mag;
            neg_ff <= prod_ff[67];
            den_ff <= {31'd0, r_eff};
            rem_ff <= 62'd0;
            quo_ff <= 64'd0;
            cnt_ff <= 6'd63;
         end
         ctg_pkg::ST_M_AY: acc_x_ff <= ctg_pkg::sat_quot(!neg_ff, quo_ff);
         ctg_pkg::ST_DONE: begin
            if (out_free) begin
               pos_x_ff   <= ctg_pkg::sat32(40'(signed'(centre_x_ff)) + 40'(px_ff));
               pos_y_ff   <= ctg_pkg::sat32(40'(signed'(centre_y_ff)) + 40'(py_ff));
               pos_z_ff   <= height_ff;
               vel_x_ff   <= ctg_pkg::sat32(40'sd0 - 40'(ps_ff));
               vel_y_ff   <= ctg_pkg::sat32(40'(pc_ff));
               acc_xo_ff  <= acc_x_ff;
               acc_y_ff   <= ctg_pkg::sat_quot(!neg_ff, quo_ff);
               yaw_out_ff <= yaw_sel;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_pos_x   = pos_x_ff;
   assign rsp_pos_y   = pos_y_ff;
   assign rsp_pos_z   = pos_z_ff;
   assign rsp_vel_x   = vel_x_ff;
   assign rsp_vel_y   = vel_y_ff;
   assign rsp_acc_x   = acc_xo_ff;
   assign rsp_acc_y   = acc_y_ff;
   assign rsp_yaw_out = yaw_out_ff;

endmodule

// File: test/tb_top.sv
// Self-checking testbench of the circle trajectory generator with a scoreboard class.
`timescale 1ns / 100ps

module tb_top;

   localparam int STEPS       = ctg_pkg::CORDIC_STEPS_DEFAULT;
   localparam int WATCH_LIMIT = 50000;
   localparam int DRAIN_WAIT  = 600;
   localparam longint unsigned SCALE_C = 64'd1608495439;
   localparam longint GAIN_Q30 = 64'sd652032874;

   typedef struct {
      logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, acc_x, acc_y, yaw_out;
   } setpoint_type;

   class setpoint_board;
      setpoint_type expected_q[$];
      int         errors;
      logic [30:0] radius;
      logic [31:0] speed, height, centre_x, centre_y;
      logic        follow;
      logic [19:0] tick;
      longint unsigned elapsed;
      logic [31:0] atan_tab[32];

      function new();
         atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                      81, 41, 20, 10, 5, 3, 1, 1, 0};
         errors   = 0;
         radius   = 31'd131072;
         speed    = 32'd65536;
         height   = 32'd65536;
         centre_x = 0;
         centre_y = 0;
         follow   = 0;
         tick     = 20'd10000;
         elapsed  = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            ctg_pkg::REG_RADIUS:   radius   = val[30:0];
            ctg_pkg::REG_SPEED:    speed    = val;
            ctg_pkg::REG_HEIGHT:   height   = val;
            ctg_pkg::REG_CENTRE_X: centre_x = val;
            ctg_pkg::REG_CENTRE_Y: centre_y = val;
            ctg_pkg::REG_YAW_MODE: follow   = val[0];
            ctg_pkg::REG_TICK:     tick     = val[19:0];
            default: ;
         endcase
      endfunction

      function longint clamp(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint q30_round(longint a, longint c);
         return (a * c + (64'sd1 <<< 29)) >>> 30;
      endfunction

      function longint quot_trunc(longint num, longint unsigned den);
         longint unsigned m;
         longint unsigned q;
         m = (num < 0) ? -num : num;
         q = m / den;
         return (num < 0) ? -longint'(q) : longint'(q);
      endfunction

      function void rotate(logic [31:0] ang, output longint c, output longint s);
         logic [1:0]  quad;
         logic [31:0] res, sum;
         longint x, y, z, nx;
         sum  = ang + 32'h2000_0000;
         quad = sum[31:30];
         res  = ang - {quad, 30'd0};
         z    = longint'(signed'(res));
         x    = GAIN_Q30;
         y    = 0;
         for (int i = 0; i < STEPS && i < 32; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               z  = z - longint'(atan_tab[i]);
            end else begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               z  = z + longint'(atan_tab[i]);
            end
            x = nx;
         end
         case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
         endcase
      endfunction

      function void note(logic [31:0] cur_yaw, logic yaw_ok);
         longint unsigned r, d, mag, a, b, rem, frac;
         longint sp, c, s, pc, ps;
         logic [31:0] ang;
         setpoint_type e;
         r   = (radius != 0) ? longint'(radius) : 1;
         d   = r * SCALE_C;
         sp  = longint'(signed'(speed));
         mag = (sp < 0) ? -sp : sp;
         elapsed = elapsed + tick;
         a   = (mag << 8) % d;
         b   = elapsed % d;
         rem = 0;
         for (int i = 61; i >= 0; i--) begin
            rem = rem << 1;
            if (rem >= d) rem = rem - d;
            if (b[i]) begin
               rem = rem + a;
               if (rem >= d) rem = rem - d;
            end
         end
         frac = 0;
         for (int i = 0; i < 32; i++) begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= d) begin
               rem  = rem - d;
               frac = frac | 1;
            end
         end
         ang = frac[31:0];
         if (sp < 0) ang = -ang;
         rotate(ang, c, s);
         pc = q30_round(sp, c);
         ps = q30_round(sp, s);
         e.pos_x = 32'(clamp(longint'(signed'(centre_x)) + q30_round(r, c)));
         e.pos_y = 32'(clamp(longint'(signed'(centre_y)) + q30_round(r, s)));
         e.pos_z = height;
         e.vel_x = 32'(clamp(-ps));
         e.vel_y = 32'(clamp(pc));
         e.acc_x = 32'(clamp(-quot_trunc(pc * sp, r)));
         e.acc_y = 32'(clamp(-quot_trunc(ps * sp, r)));
         if (follow) e.yaw_out = ang + 32'h4000_0000;
         else if (yaw_ok) e.yaw_out = cur_yaw;
         else e.yaw_out = 32'd0;
         expected_q.push_back(e);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h, expected %h", what, got, want);
         errors++;
      endtask

      task check(setpoint_type g);
         setpoint_type e;
         if (expected_q.size() == 0) begin
            report("unexpected response", g.pos_x, 0);
            return;
         end
         e = expected_q.pop_front();
         if (g.pos_x !== e.pos_x) report("pos_x", g.pos_x, e.pos_x);
         if (g.pos_y !== e.pos_y) report("pos_y", g.pos_y, e.pos_y);
         if (g.pos_z !== e.pos_z) report("pos_z", g.pos_z, e.pos_z);
         if (g.vel_x !== e.vel_x) report("vel_x", g.vel_x, e.vel_x);
         if (g.vel_y !== e.vel_y) report("vel_y", g.vel_y, e.vel_y);
         if (g.acc_x !== e.acc_x) report("acc_x", g.acc_x, e.acc_x);
         if (g.acc_y !== e.acc_y) report("acc_y", g.acc_y, e.acc_y);
         if (g.yaw_out !== e.yaw_out) report("yaw_out", g.yaw_out, e.yaw_out);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [31:0] req_current_yaw = 0;
   logic        req_yaw_valid = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_vel_x, rsp_vel_y;
   logic [31:0] rsp_acc_x, rsp_acc_y, rsp_yaw_out;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [4:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   setpoint_board board = new();
   int  stall_mode = 0;
   int  hold_cycles = 0;
   int  idle_mode = 0;
   int  burst_left = 0;
   int  quiet = 0;

   always #2 clock = ~clock;

   circle_trajectory_generator dut (.*);

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1;
         hold_cycles--;
      end else begin
         case (stall_mode)
            0: rsp_stall = 0;
            1: rsp_stall = ($urandom_range(99) < 35);
            default: rsp_stall = (($urandom_range(7) & 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      setpoint_type g;
      if (!reset && rsp_valid && !rsp_stall) begin
         g.pos_x = rsp_pos_x; g.pos_y = rsp_pos_y; g.pos_z = rsp_pos_z;
         g.vel_x = rsp_vel_x; g.vel_y = rsp_vel_y;
         g.acc_x = rsp_acc_x; g.acc_y = rsp_acc_y; g.yaw_out = rsp_yaw_out;
         board.check(g);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet = 0;
      else quiet++;
      if (quiet >= WATCH_LIMIT) begin
         $display("circle_trajectory_generator regression: fail");
         $finish;
      end
   end

   task csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel = 1; csr_pwrite = 1; csr_penable = 0;
      csr_paddr = {idx, 2'b00}; csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
      board.set_reg(idx, val);
   endtask

   task send_tick(logic [31:0] cur_yaw, logic yaw_ok);
      int gap;
      @(negedge clock);
      req_valid = 1;
      req_current_yaw = cur_yaw;
      req_yaw_valid = yaw_ok;
      do @(posedge clock); while (req_stall);
      board.note(cur_yaw, yaw_ok);
      if (idle_mode != 0) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(30, 1);
            gap = $urandom_range(20, 1);
            @(negedge clock);
            req_valid = 0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task drain;
      @(negedge clock);
      req_valid = 0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task write_all(logic [30:0] r, logic [31:0] sp, logic [31:0] h, logic [31:0] cx,
                  logic [31:0] cy, logic fol, logic [19:0] tk);
      csr_write(ctg_pkg::REG_RADIUS, {1'b0, r});
      csr_write(ctg_pkg::REG_SPEED, sp);
      csr_write(ctg_pkg::REG_HEIGHT, h);
      csr_write(ctg_pkg::REG_CENTRE_X, cx);
      csr_write(ctg_pkg::REG_CENTRE_Y, cy);
      csr_write(ctg_pkg::REG_YAW_MODE, {31'd0, fol});
      csr_write(ctg_pkg::REG_TICK, {12'd0, tk});
   endtask

   initial begin
      logic [30:0] r;
      logic [19:0] tk;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_tick(32'h0000_0000, 1);
      send_tick(32'hFFFF_FFFF, 1);
      send_tick(32'hFFFF_FFFF, 0);
      send_tick(32'h8000_0000, 1);
      send_tick(32'h7FFF_FFFF, 1);
      drain();
      write_all(31'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                1, 20'hFFFFF);
      csr_write(3'd7, 32'hFFFF_FFFF);
      repeat (4) send_tick($urandom, $urandom_range(1));
      drain();
      write_all(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 0, 20'd0);
      repeat (4) send_tick($urandom, $urandom_range(1));
      drain();
      write_all(31'd1, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 1, 20'd1);
      repeat (4) send_tick($urandom, $urandom_range(1));
      drain();
      write_all(31'd65536, 32'hFFFF_0000, 32'd0, 32'd0, 32'd0, 0, 20'd250000);
      repeat (4) send_tick($urandom, $urandom_range(1));
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(3))
            0: r = $urandom_range(32'h40000, 1);
            1: r = $urandom;
            2: r = $urandom_range(255);
            default: r = $urandom_range(32'h800000, 32'h8000);
         endcase
         tk = ($urandom_range(1) != 0) ? 20'($urandom) : 20'($urandom_range(20000));
         write_all(r, ($urandom_range(1) != 0) ? $urandom : $urandom_range(32'h60000) -
                   32'h30000, $urandom, $urandom, $urandom, $urandom_range(1), tk);
         stall_mode = ph % 3;
         idle_mode  = (ph % 4 == 0) ? 0 : 1;
         burst_left = 0;
         @(posedge clock);
         if (ph == 2) hold_cycles = 3000;
         repeat (125) send_tick($urandom, $urandom_range(1));
         drain();
      end

      if (board.errors == 0) begin
         $display("circle_trajectory_generator regression: pass");
      end else begin
         $display("circle_trajectory_generator regression: fail");
      end
      $finish;
   end
endmodule
